/* src/ftwc_pkg.sv */
// ----------------------------------------------------------------------------
// ftwc_pkg
// shared types and constants for the footprint terrain walkability check
// ----------------------------------------------------------------------------
package ftwc_pkg;

    localparam int DEF_GRID_WIDTH    = 256;
    localparam int DEF_GRID_HEIGHT   = 256;
    localparam int DEF_MAX_FOOTPRINT = 16;

    // wide enough for any grid coordinate plus a footprint span
    localparam int COORD_W   = 13;
    // compare width for footprint clamping (register is 5 bits, so at most 31)
    localparam int FP_CMP_W  = 7;
    localparam int HEIGHT_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 8;
    localparam int FP_REG_W  = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WATER_LEVEL     = 3'd0,
        CFG_FOOTPRINT_WIDTH = 3'd1,
        CFG_FOOTPRINT_DEPTH = 3'd2,
        CFG_MAX_LAND_SLOPE  = 3'd3,
        CFG_MAX_WATER_SLOPE = 3'd4,
        CFG_MIN_WATER_DEPTH = 3'd5,
        CFG_MAX_WATER_DEPTH = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        REASON_OK    = 2'd0,
        REASON_STEEP = 2'd1,
        REASON_DEPTH = 2'd2,
        REASON_GRID  = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    localparam logic [1:0] CORNER_FIRST = 2'd0;
    localparam logic [1:0] CORNER_LAST  = 2'd3;

    typedef struct packed {
        logic       start;
        logic       rd_valid;
        logic [1:0] corner;
    } t_eval_ctrl;

    typedef struct packed {
        logic steep;
        logic depth_fail;
    } t_eval_stat;

    typedef struct packed {
        logic [HEIGHT_W-1:0] water_level;
        logic [HEIGHT_W-1:0] max_land_slope;
        logic [HEIGHT_W-1:0] max_water_slope;
        logic [HEIGHT_W-1:0] min_water_depth;
        logic [HEIGHT_W-1:0] max_water_depth;
    } t_eval_cfg;

endpackage

/* src/ftwc_eval.sv */
// ----------------------------------------------------------------------------
// ftwc_eval
// shared compare unit: takes one height per cycle while rd_valid is set, folds corner min/max,
// cell slope maximum, wet flag and depth bounds check
// ----------------------------------------------------------------------------
module ftwc_eval
    import ftwc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_eval_ctrl          i_ctrl,
    input  t_eval_cfg           i_cfg,
    input  logic [HEIGHT_W-1:0] i_rd_data,
    output t_eval_stat          o_stat
);

    logic                r_wet;
    logic                r_depth_fail;
    logic                r_cell_done;
    logic [HEIGHT_W-1:0] r_max_slope;
    logic [HEIGHT_W-1:0] r_hi;
    logic [HEIGHT_W-1:0] r_lo;

    logic [HEIGHT_W-1:0] n_hi;
    logic [HEIGHT_W-1:0] n_lo;
    logic [HEIGHT_W-1:0] w_depth;
    logic [HEIGHT_W-1:0] w_slope;
    logic [HEIGHT_W-1:0] w_limit;
    logic                w_below;
    logic                w_dfail;

    always_comb begin
        w_below = i_rd_data < i_cfg.water_level;
        w_depth = w_below ? (i_cfg.water_level - i_rd_data) : '0;
        w_dfail = (w_depth < i_cfg.min_water_depth) || (w_depth > i_cfg.max_water_depth);
        if (i_ctrl.corner == CORNER_FIRST) begin
            n_hi = i_rd_data;
            n_lo = i_rd_data;
        end else begin
            n_hi = (i_rd_data > r_hi) ? i_rd_data : r_hi;
            n_lo = (i_rd_data < r_lo) ? i_rd_data : r_lo;
        end
        w_slope = r_hi - r_lo;
        w_limit = r_wet ? i_cfg.max_water_slope : i_cfg.max_land_slope;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wet        <= 1'b0;
            r_depth_fail <= 1'b0;
            r_cell_done  <= 1'b0;
            r_max_slope  <= '0;
        end else if (i_ctrl.start) begin
            r_wet        <= 1'b0;
            r_depth_fail <= 1'b0;
            r_cell_done  <= 1'b0;
            r_max_slope  <= '0;
        end else begin
            r_cell_done <= i_ctrl.rd_valid && (i_ctrl.corner == CORNER_LAST);
            if (i_ctrl.rd_valid && w_below) begin
                r_wet <= 1'b1;
            end
            // depth is taken at the cell's own corner only
            if (i_ctrl.rd_valid && (i_ctrl.corner == CORNER_FIRST) && w_dfail) begin
                r_depth_fail <= 1'b1;
            end
            if (r_cell_done && (w_slope > r_max_slope)) begin
                r_max_slope <= w_slope;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.rd_valid) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_stat.steep      = r_max_slope > w_limit;
    assign o_stat.depth_fail = r_depth_fail;

endmodule

/* src/footprint_terrain_walkability_check.sv */
// ----------------------------------------------------------------------------
// footprint_terrain_walkability_check
// write item: height stored at the accept edge if the cell is in the grid, no result
// query item: reads the four corner heights of every footprint cell from the single-port
//   heightmap in ST_READ, drains in ST_DRAIN, answers in ST_DONE; out-of-grid skips the reads
// read port (one height per cycle) bounds the rate; no item taken till the query result loads
// reset sets state, valid flags and config registers to defaults; heightmap is left undefined
// ----------------------------------------------------------------------------
module footprint_terrain_walkability_check
    import ftwc_pkg::*;
#(
    parameter int GRID_WIDTH    = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT   = DEF_GRID_HEIGHT,
    parameter int MAX_FOOTPRINT = DEF_MAX_FOOTPRINT
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [7:0]           i_cell_x,
    input  logic [7:0]           i_cell_y,
    input  logic [7:0]           i_height_value,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_walkable,
    output logic [1:0]           o_reason,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    localparam int XW    = (GRID_WIDTH  > 2) ? $clog2(GRID_WIDTH)  : 1;
    localparam int YW    = (GRID_HEIGHT > 2) ? $clog2(GRID_HEIGHT) : 1;
    localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int FPW   = (MAX_FOOTPRINT > 1) ? $clog2(MAX_FOOTPRINT + 1) : 1;
    localparam logic [AW-1:0]       GW_A   = AW'(GRID_WIDTH);
    localparam logic [COORD_W-1:0]  GW_C   = COORD_W'(GRID_WIDTH);
    localparam logic [COORD_W-1:0]  GH_C   = COORD_W'(GRID_HEIGHT);
    localparam logic [FP_CMP_W-1:0] MAXF_C = FP_CMP_W'(MAX_FOOTPRINT);

    // config registers
    logic [HEIGHT_W-1:0] r_water_level;
    logic [FP_REG_W-1:0] r_fp_width;
    logic [FP_REG_W-1:0] r_fp_depth;
    logic [HEIGHT_W-1:0] r_max_land_slope;
    logic [HEIGHT_W-1:0] r_max_water_slope;
    logic [HEIGHT_W-1:0] r_min_water_depth;
    logic [HEIGHT_W-1:0] r_max_water_depth;

    t_state r_state;
    t_state n_state;

    logic [XW-1:0]       r_x;
    logic [YW-1:0]       r_y;
    logic [FPW-1:0]      r_fw;
    logic [FPW-1:0]      r_fd;
    logic [FPW-1:0]      r_i;
    logic [FPW-1:0]      r_j;
    logic [1:0]          r_c;
    logic                r_rd_valid;
    logic [1:0]          r_rd_corner;
    logic                r_drain;
    logic                r_grid;
    logic                r_out_valid;
    logic                r_walkable;
    logic [1:0]          r_reason;
    logic [HEIGHT_W-1:0] r_rd_data;

    logic [HEIGHT_W-1:0] mem [DEPTH];

    logic                w_accept;
    logic                w_query;
    logic                w_out_free;
    logic                w_grid;
    logic                w_wr_in_grid;
    logic                w_mem_we;
    logic                w_rd_en;
    logic                w_last;
    logic                w_out_load;
    logic [FPW-1:0]      w_fwc;
    logic [FPW-1:0]      w_fdc;
    logic [COORD_W-1:0]  w_scan_x;
    logic [COORD_W-1:0]  w_scan_y;
    logic [XW-1:0]       w_addr_x;
    logic [YW-1:0]       w_addr_y;
    logic [AW-1:0]       w_addr;
    t_reason             w_reason;
    t_eval_ctrl          w_ctrl;
    t_eval_cfg           w_cfg;
    t_eval_stat          w_stat;

    // footprint clamp to 1..MAX_FOOTPRINT
    always_comb begin
        if (r_fp_width == '0) begin
            w_fwc = FPW'(1);
        end else if (FP_CMP_W'(r_fp_width) > MAXF_C) begin
            w_fwc = FPW'(MAX_FOOTPRINT);
        end else begin
            w_fwc = FPW'(r_fp_width);
        end
        if (r_fp_depth == '0) begin
            w_fdc = FPW'(1);
        end else if (FP_CMP_W'(r_fp_depth) > MAXF_C) begin
            w_fdc = FPW'(MAX_FOOTPRINT);
        end else begin
            w_fdc = FPW'(r_fp_depth);
        end
    end

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_query      = w_accept && i_mode;
    assign w_out_free   = !r_out_valid || i_out_ready;
    assign w_grid       = (COORD_W'(i_cell_x) + COORD_W'(w_fwc) >= GW_C)
                       || (COORD_W'(i_cell_y) + COORD_W'(w_fdc) >= GH_C);
    assign w_wr_in_grid = (COORD_W'(i_cell_x) < GW_C) && (COORD_W'(i_cell_y) < GH_C);
    assign w_last       = (r_c == CORNER_LAST) && (r_i == r_fw - FPW'(1))
                       && (r_j == r_fd - FPW'(1));

    // one address multiplier shared by writes and scan reads
    always_comb begin
        w_scan_x = COORD_W'(r_x) + COORD_W'(r_i) + COORD_W'(r_c[0]);
        w_scan_y = COORD_W'(r_y) + COORD_W'(r_j) + COORD_W'(r_c[1]);
        if (r_state == ST_IDLE) begin
            w_addr_x = XW'(i_cell_x);
            w_addr_y = YW'(i_cell_y);
        end else begin
            w_addr_x = XW'(w_scan_x);
            w_addr_y = YW'(w_scan_y);
        end
        w_addr = AW'(w_addr_y) * GW_A + AW'(w_addr_x);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_query) begin
                    n_state = w_grid ? ST_DONE : ST_READ;
                end
            end
            ST_READ: begin
                if (w_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (r_drain) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_rd_en    = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            ST_IDLE:  o_in_ready = 1'b1;
            ST_READ:  w_rd_en    = 1'b1;
            ST_DRAIN: ;
            ST_DONE:  w_out_load = w_out_free;
            default:  ;
        endcase
    end

    assign w_mem_we = w_accept && !i_mode && w_wr_in_grid;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_addr] <= i_height_value;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[w_addr];
        end
    end

    always_comb begin
        if (r_grid) begin
            w_reason = REASON_GRID;
        end else if (w_stat.steep) begin
            w_reason = REASON_STEEP;
        end else if (w_stat.depth_fail) begin
            w_reason = REASON_DEPTH;
        end else begin
            w_reason = REASON_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_rd_valid        <= 1'b0;
            r_drain           <= 1'b0;
            r_out_valid       <= 1'b0;
            r_water_level     <= '0;
            r_fp_width        <= FP_REG_W'(1);
            r_fp_depth        <= FP_REG_W'(1);
            r_max_land_slope  <= '1;
            r_max_water_slope <= '1;
            r_min_water_depth <= '0;
            r_max_water_depth <= '1;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= w_rd_en;
            r_drain    <= (r_state == ST_DRAIN);
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WATER_LEVEL:     r_water_level     <= i_cfg_data;
                    CFG_FOOTPRINT_WIDTH: r_fp_width        <= i_cfg_data[FP_REG_W-1:0];
                    CFG_FOOTPRINT_DEPTH: r_fp_depth        <= i_cfg_data[FP_REG_W-1:0];
                    CFG_MAX_LAND_SLOPE:  r_max_land_slope  <= i_cfg_data;
                    CFG_MAX_WATER_SLOPE: r_max_water_slope <= i_cfg_data;
                    CFG_MIN_WATER_DEPTH: r_min_water_depth <= i_cfg_data;
                    CFG_MAX_WATER_DEPTH: r_max_water_depth <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // scan counters: corner, then column, then row
    always_ff @(posedge i_clk) begin
        r_rd_corner <= r_c;
        if (w_query) begin
            r_x    <= XW'(i_cell_x);
            r_y    <= YW'(i_cell_y);
            r_fw   <= w_fwc;
            r_fd   <= w_fdc;
            r_grid <= w_grid;
            r_i    <= '0;
            r_j    <= '0;
            r_c    <= CORNER_FIRST;
        end else if (w_rd_en) begin
            r_c <= r_c + 2'd1;
            if (r_c == CORNER_LAST) begin
                if (r_i == r_fw - FPW'(1)) begin
                    r_i <= '0;
                    r_j <= r_j + FPW'(1);
                end else begin
                    r_i <= r_i + FPW'(1);
                end
            end
        end
        if (w_out_load) begin
            r_walkable <= (w_reason == REASON_OK);
            r_reason   <= w_reason;
        end
    end

    assign w_ctrl.start    = w_query;
    assign w_ctrl.rd_valid = r_rd_valid;
    assign w_ctrl.corner   = r_rd_corner;

    assign w_cfg.water_level     = r_water_level;
    assign w_cfg.max_land_slope  = r_max_land_slope;
    assign w_cfg.max_water_slope = r_max_water_slope;
    assign w_cfg.min_water_depth = r_min_water_depth;
    assign w_cfg.max_water_depth = r_max_water_depth;

    ftwc_eval u_eval (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_cfg     (w_cfg),
        .i_rd_data (r_rd_data),
        .o_stat    (w_stat)
    );

    assign o_out_valid = r_out_valid;
    assign o_walkable  = r_walkable;
    assign o_reason    = r_reason;

    // the heightmap is never written while a query scans it
    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !w_mem_we)
        else $error("heightmap written during a query");

    // read data flagged valid only for a read issued in the scan state
    a_rd_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_valid |-> $past(r_state == ST_READ))
        else $error("read data valid without a scan read");

    // a finished query always lands in the output register
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished query not delivered");

    // walkable and reason agree
    a_walk_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_walkable == (r_reason == REASON_OK)))
        else $error("walkable flag disagrees with reason");

endmodule

/* sim/footprint_terrain_walkability_check_tb.sv */
// ----------------------------------------------------------------------------
// footprint_terrain_walkability_check_tb
// drives height writes and walkability queries through the valid/ready input,
// predicts every query answer from a local copy of the heightmap and the
// registers, and compares each result in order; both sides idle at random
// ----------------------------------------------------------------------------
module footprint_terrain_walkability_check_tb;
    import ftwc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int   GRID_W     = DEF_GRID_WIDTH;
    localparam int   GRID_H     = DEF_GRID_HEIGHT;
    localparam int   FP_MAX     = DEF_MAX_FOOTPRINT;
    localparam int   STALL_LIMIT = 20000;

    typedef struct {
        logic    walkable;
        t_reason reason;
    } t_walk_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic                 i_mode = MODE_WRITE;
    logic [7:0]           i_cell_x = 8'd0;
    logic [7:0]           i_cell_y = 8'd0;
    logic [7:0]           i_height_value = 8'd0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic                 o_walkable;
    logic [1:0]           o_reason;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_WATER_LEVEL;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    // local terrain and register copies
    logic [7:0] terrain [0:GRID_W*GRID_H-1];
    bit         terrain_set [0:GRID_W*GRID_H-1];
    logic [7:0] cfg_water = 8'd0;
    logic [4:0] cfg_fw = 5'd1;
    logic [4:0] cfg_fd = 5'd1;
    logic [7:0] cfg_land_slope = 8'd255;
    logic [7:0] cfg_water_slope = 8'd255;
    logic [7:0] cfg_min_depth = 8'd0;
    logic [7:0] cfg_max_depth = 8'd255;

    t_walk_result pending_q[$];
    int n_errors = 0;
    int n_sent = 0;
    int idle_cycles = 0;
    int hold_left = 0;
    int rx_stall = 0;
    bit steady_flow = 1'b0;

    footprint_terrain_walkability_check u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_cell_x       (i_cell_x),
        .i_cell_y       (i_cell_y),
        .i_height_value (i_height_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_walkable     (o_walkable),
        .o_reason       (o_reason),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int fp_size(input logic [4:0] v);
        if (v == 0) return 1;
        if (v > FP_MAX) return FP_MAX;
        return int'(v);
    endfunction

    function automatic int height_at(input int x, input int y);
        return terrain[y*GRID_W + x];
    endfunction

    function automatic t_reason walk_reason(input logic [7:0] x, input logic [7:0] y);
        int fw, fd, xi, yi, wl, lim, lo, hi, h, d;
        bit wet;
        fw = fp_size(cfg_fw);
        fd = fp_size(cfg_fd);
        xi = x;
        yi = y;
        wl = cfg_water;
        if (xi + fw >= GRID_W || yi + fd >= GRID_H) return REASON_GRID;
        wet = 1'b0;
        for (int j = 0; j <= fd; j++)
            for (int i = 0; i <= fw; i++)
                if (height_at(xi + i, yi + j) < wl) wet = 1'b1;
        lim = wet ? int'(cfg_water_slope) : int'(cfg_land_slope);
        for (int j = 0; j < fd; j++)
            for (int i = 0; i < fw; i++) begin
                lo = 255;
                hi = 0;
                for (int c = 0; c < 4; c++) begin
                    h = height_at(xi + i + c % 2, yi + j + c / 2);
                    if (h < lo) lo = h;
                    if (h > hi) hi = h;
                end
                if (hi - lo > lim) return REASON_STEEP;
            end
        for (int j = 0; j < fd; j++)
            for (int i = 0; i < fw; i++) begin
                h = height_at(xi + i, yi + j);
                d = (h < wl) ? wl - h : 0;
                if (d < int'(cfg_min_depth) || d > int'(cfg_max_depth)) return REASON_DEPTH;
            end
        return REASON_OK;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic int sender_gap();
        if (steady_flow || $urandom_range(0, 1) == 0) return 0;
        return idle_len();
    endfunction

    // heights cluster around the water level so slope and depth limits bite
    function automatic logic [7:0] pick_height();
        int h;
        case ($urandom_range(0, 9))
            0: h = $urandom_range(0, 255);
            1: h = $urandom_range(0, 1) ? 255 : 0;
            default: begin
                h = $urandom_range(0, 16);
                h = h + int'(cfg_water) - 8;
            end
        endcase
        if (h < 0) h = 0;
        else if (h > 255) h = 255;
        return h[7:0];
    endfunction

    function automatic logic [7:0] pick_level(input int lo, input int hi);
        case ($urandom_range(0, 6))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(lo, hi));
        endcase
    endfunction

    function automatic logic [7:0] pick_fp();
        case ($urandom_range(0, 19))
            0: return 8'd0;
            1: return 8'($urandom_range(5, 8));
            default: return 8'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic note_error(input string what);
        n_errors++;
        if (n_errors <= 10) $display("%t: %s", $realtime, what);
    endtask

    // ends at the posedge where the item is taken
    task automatic send_item(input logic mode, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] h);
        int gap;
        t_walk_result r;
        gap = sender_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_cell_x       <= x;
        i_cell_y       <= y;
        i_height_value <= h;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        n_sent++;
        if (mode == MODE_WRITE) begin
            terrain[{y, x}]     = h;
            terrain_set[{y, x}] = 1'b1;
        end else begin
            r.reason   = walk_reason(x, y);
            r.walkable = (r.reason == REASON_OK);
            pending_q.push_back(r);
        end
    endtask

    task automatic stop_input();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // a write gives no result, so pause after the queue empties to let it settle
    task automatic wait_drained();
        stop_input();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic set_cfg(input t_cfg_idx idx, input logic [7:0] data);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            CFG_WATER_LEVEL:     cfg_water = data;
            CFG_FOOTPRINT_WIDTH: cfg_fw = data[4:0];
            CFG_FOOTPRINT_DEPTH: cfg_fd = data[4:0];
            CFG_MAX_LAND_SLOPE:  cfg_land_slope = data;
            CFG_MAX_WATER_SLOPE: cfg_water_slope = data;
            CFG_MIN_WATER_DEPTH: cfg_min_depth = data;
            CFG_MAX_WATER_DEPTH: cfg_max_depth = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // fill any unwritten heights under the window first, then ask
    task automatic query_at(input int x, input int y);
        int fw, fd;
        fw = fp_size(cfg_fw);
        fd = fp_size(cfg_fd);
        if (x + fw < GRID_W && y + fd < GRID_H)
            for (int j = 0; j <= fd; j++)
                for (int i = 0; i <= fw; i++)
                    if (!terrain_set[(y + j)*GRID_W + x + i])
                        send_item(MODE_WRITE, 8'(x + i), 8'(y + j), pick_height());
        send_item(MODE_QUERY, 8'(x), 8'(y), 8'($urandom()));
    endtask

    task automatic test_directed_cases();
        // steep patch at the origin, flat patch in the far corner
        send_item(MODE_WRITE, 8'd0, 8'd0, 8'd0);
        send_item(MODE_WRITE, 8'd1, 8'd0, 8'd255);
        send_item(MODE_WRITE, 8'd0, 8'd1, 8'd0);
        send_item(MODE_WRITE, 8'd1, 8'd1, 8'd255);
        send_item(MODE_WRITE, 8'd254, 8'd254, 8'd255);
        send_item(MODE_WRITE, 8'd255, 8'd254, 8'd255);
        send_item(MODE_WRITE, 8'd254, 8'd255, 8'd255);
        send_item(MODE_WRITE, 8'd255, 8'd255, 8'd255);
        query_at(0, 0);
        query_at(254, 254);
        query_at(255, 254);
        query_at(254, 255);
        query_at(255, 255);
        set_cfg(CFG_MAX_LAND_SLOPE, 8'd254);
        query_at(0, 0);
        query_at(254, 254);
        // water level set to its maximum
        set_cfg(CFG_WATER_LEVEL, 8'd255);
        query_at(0, 0);
        set_cfg(CFG_MAX_WATER_DEPTH, 8'd254);
        query_at(0, 0);
        set_cfg(CFG_MIN_WATER_DEPTH, 8'd10);
        query_at(254, 254);
        // empty depth range
        set_cfg(CFG_MIN_WATER_DEPTH, 8'd200);
        set_cfg(CFG_MAX_WATER_DEPTH, 8'd100);
        query_at(254, 254);
        // steep and out of depth range together
        set_cfg(CFG_MAX_WATER_SLOPE, 8'd0);
        query_at(0, 0);
        set_cfg(CFG_WATER_LEVEL, 8'd1);
        query_at(0, 0);
        query_at(254, 254);
    endtask

    task automatic test_large_footprint();
        set_cfg(CFG_WATER_LEVEL, 8'd128);
        set_cfg(CFG_FOOTPRINT_WIDTH, 8'hFF);
        set_cfg(CFG_FOOTPRINT_DEPTH, 8'd16);
        set_cfg(CFG_MAX_LAND_SLOPE, 8'd255);
        set_cfg(CFG_MAX_WATER_SLOPE, 8'd255);
        set_cfg(CFG_MIN_WATER_DEPTH, 8'd0);
        set_cfg(CFG_MAX_WATER_DEPTH, 8'd255);
        query_at(239, 239);
        query_at(240, 239);
        query_at(239, 240);
        set_cfg(CFG_MAX_WATER_SLOPE, 8'd8);
        query_at(239, 239);
        set_cfg(CFG_FOOTPRINT_DEPTH, 8'd17);
        set_cfg(CFG_MAX_WATER_SLOPE, 8'd255);
        set_cfg(CFG_MAX_WATER_DEPTH, 8'd4);
        query_at(239, 239);
        // zero footprint registers act as one cell
        set_cfg(CFG_FOOTPRINT_WIDTH, 8'hE0);
        set_cfg(CFG_FOOTPRINT_DEPTH, 8'd0);
        query_at(250, 250);
        query_at(255, 250);
    endtask

    task automatic test_output_holdoff();
        set_cfg(CFG_FOOTPRINT_WIDTH, 8'd2);
        set_cfg(CFG_FOOTPRINT_DEPTH, 8'd3);
        hold_left = 400;
        repeat (24) query_at($urandom_range(0, 10), $urandom_range(0, 10));
        wait_drained();
    endtask

    task automatic randomize_config();
        set_cfg(CFG_WATER_LEVEL, pick_level(40, 200));
        set_cfg(CFG_FOOTPRINT_WIDTH, pick_fp());
        set_cfg(CFG_FOOTPRINT_DEPTH, pick_fp());
        set_cfg(CFG_MAX_LAND_SLOPE, pick_level(0, 20));
        set_cfg(CFG_MAX_WATER_SLOPE, pick_level(0, 20));
        set_cfg(CFG_MIN_WATER_DEPTH, ($urandom_range(0, 9) < 6) ? 8'd0 : pick_level(0, 6));
        set_cfg(CFG_MAX_WATER_DEPTH, pick_level(2, 12));
    endtask

    task automatic random_item();
        int ax, ay, fw, fd, r;
        fw = fp_size(cfg_fw);
        fd = fp_size(cfg_fd);
        case ($urandom_range(0, 3))
            0: begin ax = 0;   ay = 0;   end
            1: begin ax = 90;  ay = 40;  end
            2: begin ax = 170; ay = 200; end
            default: begin ax = 236; ay = 236; end
        endcase
        r = $urandom_range(0, 99);
        if (r < 45) begin
            query_at(ax + $urandom_range(0, 10), ay + $urandom_range(0, 10));
        end else if (r < 75) begin
            // reshape terrain where queries land
            send_item(MODE_WRITE, 8'(ax + $urandom_range(0, 12)),
                      8'(ay + $urandom_range(0, 12)), pick_height());
        end else if (r < 85) begin
            send_item(MODE_WRITE, 8'($urandom()), 8'($urandom()), 8'($urandom()));
        end else if ($urandom_range(0, 1)) begin
            query_at($urandom_range(GRID_W - fw, 255), $urandom_range(0, 255));
        end else begin
            query_at($urandom_range(0, 255), $urandom_range(GRID_H - fd, 255));
        end
    endtask

    task automatic test_random_terrain();
        int round_end;
        for (int r = 0; r < 8; r++) begin
            randomize_config();
            steady_flow = (r % 3 == 2);
            round_end = n_sent + 125;
            while (n_sent < round_end) random_item();
        end
        steady_flow = 1'b0;
    endtask

    // result side: random stalls plus the long hold-off when asked
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (rx_stall > 0) begin
            i_out_ready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!steady_flow && $urandom_range(0, 3) == 0) rx_stall = idle_len();
        end
    end

    always @(posedge i_clk) begin : result_check
        t_walk_result exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_q.size() == 0) begin
                note_error($sformatf("unexpected result walkable %0d reason %0d",
                                     o_walkable, o_reason));
            end else begin
                exp_r = pending_q.pop_front();
                if (o_walkable !== exp_r.walkable || o_reason !== exp_r.reason)
                    note_error($sformatf("walkable exp %0d got %0d, reason exp %0d got %0d",
                                         exp_r.walkable, o_walkable, exp_r.reason, o_reason));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("footprint_terrain_walkability_check verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_large_footprint();
        test_output_holdoff();
        test_random_terrain();
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && pending_q.size() == 0) begin
            $display("footprint_terrain_walkability_check verification clean");
        end else begin
            $display("footprint_terrain_walkability_check verification failed");
        end
        $finish;
    end

endmodule
